/* rtl/rpwc_pkg.sv */
// ----------------------------------------------------------------------------
// rpwc_pkg: shared types and constants
// Sizes, command classes, status codes and payload structs for the radix
// partitioner with write-combining line buffers.
// ----------------------------------------------------------------------------
package rpwc_pkg;

  localparam int MAX_KEYS    = 4096;
  localparam int KEY_AW      = 12;     // key and result store address
  localparam int CNT_W       = 13;     // counts and positions up to MAX_KEYS
  localparam int PART_W      = 8;      // bucket index, MAX_PARTITIONS = 256
  localparam int MAX_LOG2    = 8;
  localparam int LINE_TUPLES = 8;
  localparam int LINE_AW     = 3;
  localparam int LB_AW       = PART_W + LINE_AW;
  localparam int KEY_W       = 64;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RUN  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic [3:0] LOG2_RESET = 4'd4;

  typedef struct packed {
    logic [1:0]        func;
    logic [KEY_W-1:0]  key;
    logic [KEY_AW-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] read_data;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [KEY_AW-1:0] idx;
  } cmd_t;

endpackage

/* rtl/radix_partitioner_write_combining_unit.sv */
// ----------------------------------------------------------------------------
// radix_partitioner_write_combining_unit: radix partitioner top level
// Loads: one per cycle while idle and the result queue is not full.
// Reads: a valid read is finished before the next command is taken.
// Run: walks the bucket and result memories one step a cycle; no other
//   command is taken until the run has finished.
// Reset (synchronous, rst high) empties both queues, clears the key count and
//   run flag and sets log2_partitions to 4; the memories hold no reset value.
// ----------------------------------------------------------------------------
module radix_partitioner_write_combining_unit import rpwc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   request,
  output logic       empty,
  input  logic       pop,
  output out_item_t  result,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  cmd_t      cmd;
  logic      cmd_valid;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_out;

  rpwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  rpwc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res_out)
  );

  rpwc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_out),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

/* rtl/rpwc_front.sv */
// ----------------------------------------------------------------------------
// rpwc_front: command intake
// Accepts input transactions, classifies func into a command class and
// holds up to two commands for the back end.
// ----------------------------------------------------------------------------
module rpwc_front import rpwc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t request,
  output logic     cmd_valid,
  input  logic     cmd_pop,
  output cmd_t     cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       classed;

  always_comb begin
    classed.key = request.key;
    classed.idx = request.read_index;
    case (request.func)
      FUNC_LOAD: classed.op = OP_LOAD;
      FUNC_RUN:  classed.op = OP_RUN;
      FUNC_READ: classed.op = OP_READ;
      default:   classed.op = OP_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= classed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* rtl/rpwc_outq.sv */
// ----------------------------------------------------------------------------
// rpwc_outq: result queue
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module rpwc_outq import rpwc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      res_push,
  input  out_item_t res_in,
  output logic      res_full,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign result   = slots[rd_ptr];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      slots[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(res_push) - 2'(do_pop);
    end
  end

endmodule

/* rtl/rpwc_back.sv */
// ----------------------------------------------------------------------------
// rpwc_back: command execution
// Owns the key, result, bucket and line-buffer memories and sequences loads,
// reads and the multi-phase partitioning run.
// ----------------------------------------------------------------------------
module rpwc_back import rpwc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  cmd_t       cmd,
  input  logic       res_full,
  output logic       res_push,
  output out_item_t  res_out
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDW   = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_C_KEY = 5'd3;
  localparam logic [4:0] S_C_BKT = 5'd4;
  localparam logic [4:0] S_C_INC = 5'd5;
  localparam logic [4:0] S_P_RD  = 5'd6;
  localparam logic [4:0] S_P_WR  = 5'd7;
  localparam logic [4:0] S_K_KEY = 5'd8;
  localparam logic [4:0] S_K_BKT = 5'd9;
  localparam logic [4:0] S_K_DEC = 5'd10;
  localparam logic [4:0] S_K_LRD = 5'd11;
  localparam logic [4:0] S_K_LWR = 5'd12;
  localparam logic [4:0] S_D_TOP = 5'd13;
  localparam logic [4:0] S_D_LO  = 5'd14;
  localparam logic [4:0] S_D_CHK = 5'd15;
  localparam logic [4:0] S_D_RRD = 5'd16;
  localparam logic [4:0] S_D_RWR = 5'd17;
  localparam logic [4:0] S_D_BUF = 5'd18;
  localparam logic [4:0] S_D_BWR = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  localparam logic [CNT_W-1:0] KEYS_MAX = CNT_W'(MAX_KEYS);
  localparam logic [CNT_W-1:0] LINE_C   = CNT_W'(LINE_TUPLES);
  localparam logic [CNT_W-1:0] CLR_END  = CNT_W'(1 << PART_W);
  localparam logic [LINE_AW-1:0] LAST_SLOT = LINE_AW'(LINE_TUPLES - 1);

  // memories
  logic [KEY_W-1:0] key_store    [MAX_KEYS];
  logic [KEY_W-1:0] result_store [MAX_KEYS];
  logic [KEY_W-1:0] line_buffers [1 << LB_AW];
  logic [CNT_W-1:0] bucket_counts  [1 << PART_W];
  logic [CNT_W-1:0] bucket_ends    [1 << PART_W];
  logic [CNT_W-1:0] write_position [1 << PART_W];
  logic [LINE_AW-1:0] buffer_fill  [1 << PART_W];

  logic              key_we, res_we, lb_we, cnt_we, end_we, wp_we, fill_we;
  logic [KEY_AW-1:0] key_raddr, res_waddr, res_raddr;
  logic [LB_AW-1:0]  lb_waddr, lb_raddr;
  logic [PART_W-1:0] cnt_waddr, cnt_raddr, end_raddr, bk_waddr, bk_raddr;
  logic [KEY_W-1:0]  res_wdata, lb_wdata;
  logic [CNT_W-1:0]  cnt_wdata, end_wdata, wp_wdata;
  logic [LINE_AW-1:0] fill_wdata;
  logic [KEY_W-1:0]  krd, rrd, lbrd;
  logic [CNT_W-1:0]  crd, erd, wprd;
  logic [LINE_AW-1:0] frd;

  // control registers
  logic [4:0]         state;
  logic [3:0]         log2_partitions;
  logic [3:0]         p;
  logic               run_done;
  logic [CNT_W-1:0]   key_count;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   running;
  logic [PART_W-1:0]  b;
  logic [LINE_AW-1:0] s;
  logic [LINE_AW-1:0] m;
  logic [LINE_AW-1:0] fb;
  logic [CNT_W-1:0]   w, t, e, j, lowr, endb;
  logic [PART_W:0]    r;
  logic [KEY_W-1:0]   kreg;

  logic               take, load_ok, read_ok;
  logic [PART_W:0]    n;
  logic [PART_W-1:0]  bkt_krd;
  logic [CNT_W-1:0]   run_sum, t_new, lower, wv;
  logic [3:0]         p_eff;

  assign n       = (PART_W + 1)'(1) << p;
  assign bkt_krd = krd[KEY_W-1 -: PART_W] >> (4'(MAX_LOG2) - p);
  assign run_sum = running + crd;
  assign t_new   = (wprd >= LINE_C) ? wprd - LINE_C : '0;
  assign lower   = (b != '0) ? erd : '0;
  assign wv      = (w <= lowr) ? endb : w;
  assign p_eff   = (log2_partitions == 4'd0) ? 4'd1 :
                   (log2_partitions > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : log2_partitions;

  assign take    = (state == S_IDLE) && cmd_valid && !res_full;
  assign load_ok = !run_done && (key_count < KEYS_MAX);
  assign read_ok = run_done && ({1'b0, cmd.idx} < key_count);
  assign cmd_pop = take;

  always_comb begin
    key_we = take && cmd.op == OP_LOAD && load_ok;
    key_raddr = i[KEY_AW-1:0];
    res_we = 1'b0; res_waddr = '0; res_wdata = lbrd;
    res_raddr = (state == S_IDLE) ? cmd.idx : j[KEY_AW-1:0];
    lb_we = 1'b0; lb_waddr = {b, s}; lb_wdata = kreg;
    lb_raddr = (state == S_K_LRD) ? {b, m} : {b, s};
    cnt_we = 1'b0; cnt_waddr = i[PART_W-1:0]; cnt_wdata = '0;
    cnt_raddr = (state == S_C_BKT) ? bkt_krd : i[PART_W-1:0];
    end_we = 1'b0; end_wdata = run_sum;
    end_raddr = (state == S_D_LO) ? b - 1'b1 : PART_W'(r - 1'b1);
    wp_we = 1'b0; fill_we = 1'b0; wp_wdata = '0; fill_wdata = '0;
    bk_waddr = i[PART_W-1:0];
    bk_raddr = (state == S_K_BKT) ? bkt_krd : PART_W'(r - 1'b1);
    res_push = 1'b0;
    res_out.read_data = '0;
    res_out.status = ST_OK;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_LOAD: begin
              res_push = 1'b1;
              res_out.status = load_ok ? ST_OK : ST_REJECT;
            end
            OP_RUN: begin
              res_push = run_done;
              res_out.status = ST_REJECT;
            end
            OP_READ: begin
              res_push = !read_ok;
              res_out.status = ST_RANGE;
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      S_RDW: begin
        res_push = 1'b1;
        res_out.read_data = rrd;
      end
      S_CLR: cnt_we = 1'b1;
      S_C_INC: begin
        cnt_we = 1'b1;
        cnt_waddr = b;
        cnt_wdata = crd + 1'b1;
      end
      S_P_WR: begin
        if (i != {{(CNT_W-PART_W-1){1'b0}}, n}) begin
          end_we = 1'b1;
          wp_we = 1'b1;
          fill_we = 1'b1;
          wp_wdata = run_sum & ~(LINE_C - 1'b1);
        end
      end
      S_K_DEC: begin
        lb_we = 1'b1;
        fill_we = 1'b1;
        bk_waddr = b;
        if (frd >= LAST_SLOT) begin
          lb_waddr = {b, LAST_SLOT};
          wp_we = 1'b1;
          wp_wdata = t_new;
        end else begin
          lb_waddr = {b, frd};
          fill_wdata = frd + 1'b1;
        end
      end
      S_K_LWR: begin
        res_we = 1'b1;
        res_waddr = KEY_AW'(t + CNT_W'(m));
      end
      S_D_RWR: begin
        res_we = 1'b1;
        res_waddr = KEY_AW'(e - 1'b1);
        res_wdata = rrd;
      end
      S_D_BWR: begin
        res_we = 1'b1;
        res_waddr = w[KEY_AW-1:0];
      end
      S_DONE: res_push = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_store[key_count[KEY_AW-1:0]] <= cmd.key;
    krd <= key_store[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (res_we) result_store[res_waddr] <= res_wdata;
    rrd <= result_store[res_raddr];
  end

  always_ff @(posedge clk) begin
    if (lb_we) line_buffers[lb_waddr] <= lb_wdata;
    lbrd <= line_buffers[lb_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) bucket_counts[cnt_waddr] <= cnt_wdata;
    crd <= bucket_counts[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (end_we) bucket_ends[i[PART_W-1:0]] <= end_wdata;
    erd <= bucket_ends[end_raddr];
  end

  always_ff @(posedge clk) begin
    if (wp_we) write_position[bk_waddr] <= wp_wdata;
    wprd <= write_position[bk_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill_we) buffer_fill[bk_waddr] <= fill_wdata;
    frd <= buffer_fill[bk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      log2_partitions <= LOG2_RESET;
      run_done <= 1'b0;
      key_count <= '0;
    end else begin
      if (cfg_we) log2_partitions <= cfg_data;
      case (state)
        S_IDLE: begin
          if (take) begin
            case (cmd.op)
              OP_LOAD: if (load_ok) key_count <= key_count + 1'b1;
              OP_RUN: begin
                if (!run_done) begin
                  p <= p_eff;
                  i <= '0;
                  state <= S_CLR;
                end
              end
              OP_READ: if (read_ok) state <= S_RDW;
              default: ;
            endcase
          end
        end
        S_RDW: state <= S_IDLE;
        S_CLR: begin
          // sweep the bucket counters to zero
          if (i == CLR_END - 1'b1) begin
            i <= '0;
            state <= S_C_KEY;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_C_KEY: begin
          if (i == key_count) begin
            i <= '0;
            running <= '0;
            state <= S_P_RD;
          end else begin
            state <= S_C_BKT;
          end
        end
        S_C_BKT: begin
          b <= bkt_krd;
          state <= S_C_INC;
        end
        S_C_INC: begin
          i <= i + 1'b1;
          state <= S_C_KEY;
        end
        S_P_RD: state <= S_P_WR;
        S_P_WR: begin
          if (i == {{(CNT_W-PART_W-1){1'b0}}, n}) begin
            i <= '0;
            state <= S_K_KEY;
          end else begin
            running <= run_sum;
            i <= i + 1'b1;
            state <= S_P_RD;
          end
        end
        S_K_KEY: begin
          if (i == key_count) begin
            r <= n;
            state <= S_D_TOP;
          end else begin
            state <= S_K_BKT;
          end
        end
        S_K_BKT: begin
          kreg <= krd;
          b <= bkt_krd;
          state <= S_K_DEC;
        end
        S_K_DEC: begin
          if (frd >= LAST_SLOT) begin
            t <= t_new;
            m <= '0;
            state <= S_K_LRD;
          end else begin
            i <= i + 1'b1;
            state <= S_K_KEY;
          end
        end
        S_K_LRD: state <= S_K_LWR;
        S_K_LWR: begin
          if (m == LAST_SLOT) begin
            i <= i + 1'b1;
            state <= S_K_KEY;
          end else begin
            m <= m + 1'b1;
            state <= S_K_LRD;
          end
        end
        S_D_TOP: begin
          // visit buckets from the highest down
          if (r == '0) begin
            state <= S_DONE;
          end else begin
            b <= PART_W'(r - 1'b1);
            state <= S_D_LO;
          end
        end
        S_D_LO: begin
          endb <= erd;
          fb <= frd;
          w <= wprd;
          state <= S_D_CHK;
        end
        S_D_CHK: begin
          lowr <= lower;
          s <= '0;
          if (b != '0 && w < lower) begin
            e <= endb;
            j <= w;
            state <= S_D_RRD;
          end else begin
            state <= S_D_BUF;
          end
        end
        S_D_RRD: begin
          // move spill below the bucket start to its top
          if (j == lowr) begin
            w <= e;
            state <= S_D_BUF;
          end else if (e != '0) begin
            state <= S_D_RWR;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_D_RWR: begin
          e <= e - 1'b1;
          j <= j + 1'b1;
          state <= S_D_RRD;
        end
        S_D_BUF: begin
          if (s == fb) begin
            r <= r - 1'b1;
            state <= S_D_TOP;
          end else if (wv != '0) begin
            w <= wv - 1'b1;
            state <= S_D_BWR;
          end else begin
            w <= wv;
            s <= s + 1'b1;
          end
        end
        S_D_BWR: begin
          s <= s + 1'b1;
          state <= S_D_BUF;
        end
        S_DONE: begin
          run_done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_run_sticky: assert property (@(posedge clk) disable iff (rst)
    run_done |=> run_done)
    else $error("run_done cleared after a run");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= KEYS_MAX)
    else $error("key_count beyond capacity");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_load_frozen: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(key_count))
    else $error("key_count changed while busy");
`endif

endmodule
